FILE: hw/rtl/ocm_pkg.sv
// Shared types, widths and reset values for the overcurrent limit monitor.
`default_nettype none

package ocm_pkg;

   localparam int LANES      = 4;
   localparam int TIME_W     = 32;
   localparam int VOLT_W     = 13;
   localparam int SCALE_W    = 20;
   localparam int AMP_W      = 16;
   localparam int TOTAL_W    = 18;
   localparam int HOLD_W     = 24;
   localparam int PROD_W     = VOLT_W + SCALE_W;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [VOLT_W-1:0]  ZERO_OFFSET_RESET = 13'd2500;
   localparam logic [SCALE_W-1:0] SCALE_RESET       = 20'd354248;
   localparam logic [AMP_W-1:0]   SOFT_LIMIT_RESET  = 16'd3000;
   localparam logic [AMP_W-1:0]   HARD_LIMIT_RESET  = 16'd8000;
   localparam logic [HOLD_W-1:0]  SOFT_HOLD_RESET   = 24'd100000;
   localparam logic [HOLD_W-1:0]  HARD_HOLD_RESET   = 24'd20000;

   typedef enum logic [1:0] {
      LEVEL_OK   = 2'd0,
      LEVEL_SOFT = 2'd1,
      LEVEL_HARD = 2'd2
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_OFFSET = 3'd0,
      CSR_SCALE       = 3'd1,
      CSR_SOFT_LIMIT  = 3'd2,
      CSR_HARD_LIMIT  = 3'd3,
      CSR_SOFT_HOLD   = 3'd4,
      CSR_HARD_HOLD   = 3'd5
   } csr_index_type;

   typedef logic [VOLT_W-1:0] volt_type;
   typedef logic [AMP_W-1:0]  amp_type;

   typedef struct packed {
      logic [VOLT_W-1:0]  zero_offset;
      logic [SCALE_W-1:0] scale;
      logic [AMP_W-1:0]   soft_limit;
      logic [AMP_W-1:0]   hard_limit;
      logic [HOLD_W-1:0]  soft_hold;
      logic [HOLD_W-1:0]  hard_hold;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]    time_us;
      amp_type [LANES-1:0]  amps;
   } mid_item_type;

   typedef struct packed {
      amp_type [LANES-1:0]   amps;
      logic [TOTAL_W-1:0]    total;
      logic [LANES-1:0]      flags;
      level_type [LANES-1:0] levels;
      logic                  estop;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: hw/rtl/overcurrent_limit_monitor_top.sv
// Top level of the four-channel two-level overcurrent limit monitor.
`default_nettype none

// Takes one request per clock cycle while full is low and returns one result per request, in order.
// A request enters the front end, which registers the product of each
// channel's voltage offset and the scale factor. The saturated currents then wait
// in a four-entry queue. The back end updates the channel timers and levels for
// one request per cycle while the result queue is not full, and writes a two-entry
// result queue; requests pass the front register, middle queue and result queue.
// full rises only once the middle queue and the front register are both occupied.
// The configuration port is always ready; registers should be written while the
// block holds no request.
module overcurrent_limit_monitor_top #(
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic [31:0]                       req_time_us,
   input  wire logic [12:0]                       req_volts_a,
   input  wire logic [12:0]                       req_volts_b,
   input  wire logic [12:0]                       req_volts_c,
   input  wire logic [12:0]                       req_volts_d,
   output logic                                   empty,
   input  wire logic                              pop,
   output logic [15:0]                            rsp_amps_a,
   output logic [15:0]                            rsp_amps_b,
   output logic [15:0]                            rsp_amps_c,
   output logic [15:0]                            rsp_amps_d,
   output logic [17:0]                            rsp_total_ma,
   output logic [3:0]                             rsp_limit_flags,
   output logic [1:0]                             rsp_level_a,
   output logic [1:0]                             rsp_level_b,
   output logic [1:0]                             rsp_level_c,
   output logic [1:0]                             rsp_level_d,
   output logic                                   rsp_estop_request,
   input  wire logic                              valid,
   output logic                                   ready,
   input  wire logic [ocm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ocm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ocm_pkg::*;

   localparam int MID_W = $bits(mid_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   cfg_type                cfg_ff, cfg_in;
   csr_index_type          csr_sel;
   volt_type [LANES-1:0]   volts;
   logic                   front_ready;
   logic                   mid_push, mid_full, mid_empty, mid_pop;
   mid_item_type           mid_wr_item, mid_rd_item;
   logic [MID_W-1:0]       mid_head;
   logic                   out_push, out_full;
   rsp_item_type           out_wr_item, out_rd_item;
   logic [RSP_W-1:0]       out_head;

   assign ready   = 1'b1;
   assign csr_sel = csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         case (csr_sel)
            CSR_ZERO_OFFSET: cfg_in.zero_offset = csr_data[VOLT_W-1:0];
            CSR_SCALE:       cfg_in.scale       = csr_data[SCALE_W-1:0];
            CSR_SOFT_LIMIT:  cfg_in.soft_limit  = csr_data[AMP_W-1:0];
            CSR_HARD_LIMIT:  cfg_in.hard_limit  = csr_data[AMP_W-1:0];
            CSR_SOFT_HOLD:   cfg_in.soft_hold   = csr_data[HOLD_W-1:0];
            CSR_HARD_HOLD:   cfg_in.hard_hold   = csr_data[HOLD_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_offset <= ZERO_OFFSET_RESET;
         cfg_ff.scale       <= SCALE_RESET;
         cfg_ff.soft_limit  <= SOFT_LIMIT_RESET;
         cfg_ff.hard_limit  <= HARD_LIMIT_RESET;
         cfg_ff.soft_hold   <= SOFT_HOLD_RESET;
         cfg_ff.hard_hold   <= HARD_HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign volts[0] = req_volts_a;
   assign volts[1] = req_volts_b;
   assign volts[2] = req_volts_c;
   assign volts[3] = req_volts_d;
   assign full     = !front_ready;

   ocm_front #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push),
      .in_ready (front_ready),
      .in_time  (req_time_us),
      .in_volts (volts),
      .cfg      (cfg_ff),
      .mid_push (mid_push),
      .mid_item (mid_wr_item),
      .mid_full (mid_full)
   );

   ocm_queue #(
      .WIDTH(MID_W),
      .DEPTH(4)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .head      (mid_head)
   );

   assign mid_rd_item = mid_item_type'(mid_head);

   ocm_back #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_valid (!mid_empty),
      .mid_item  (mid_rd_item),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_wr_item)
   );

   ocm_queue #(
      .WIDTH(RSP_W),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_item),
      .full      (out_full),
      .pop       (pop),
      .empty     (empty),
      .head      (out_head)
   );

   assign out_rd_item       = rsp_item_type'(out_head);
   assign rsp_amps_a        = out_rd_item.amps[0];
   assign rsp_amps_b        = out_rd_item.amps[1];
   assign rsp_amps_c        = out_rd_item.amps[2];
   assign rsp_amps_d        = out_rd_item.amps[3];
   assign rsp_total_ma      = out_rd_item.total;
   assign rsp_limit_flags   = out_rd_item.flags;
   assign rsp_level_a       = out_rd_item.levels[0];
   assign rsp_level_b       = out_rd_item.levels[1];
   assign rsp_level_c       = out_rd_item.levels[2];
   assign rsp_level_d       = out_rd_item.levels[3];
   assign rsp_estop_request = out_rd_item.estop;

endmodule

`default_nettype wire

FILE: hw/rtl/ocm_queue.sv
// Small first-in first-out queue of fixed-width words.
`default_nettype none

module ocm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      head
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ocm_front.sv
// Front end: takes requests, converts each voltage into a saturated current.
`default_nettype none

module ocm_front #(
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   output logic                                          in_ready,
   input  wire logic [ocm_pkg::TIME_W-1:0]               in_time,
   input  wire ocm_pkg::volt_type [ocm_pkg::LANES-1:0]   in_volts,
   input  wire ocm_pkg::cfg_type                         cfg,
   output logic                                          mid_push,
   output ocm_pkg::mid_item_type                         mid_item,
   input  wire logic                                     mid_full
);
   import ocm_pkg::*;

   logic                vld_ff, vld_in;
   logic [TIME_W-1:0]   time_ff;
   logic [PROD_W-1:0]   prod_ff [LANES];
   logic [PROD_W-1:0]   prod_in [LANES];
   logic [VOLT_W-1:0]   diff [LANES];
   logic                load;

   assign in_ready = !vld_ff || !mid_full;
   assign load     = in_valid && in_ready;
   assign mid_push = vld_ff && !mid_full;

   always_comb begin
      vld_in = in_ready ? in_valid : vld_ff;
   end

   // One multiplier per channel; unused lanes hold a zero product.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         diff[i] = (in_volts[i] >= cfg.zero_offset) ? in_volts[i] - cfg.zero_offset
                                                    : cfg.zero_offset - in_volts[i];
         if (i < NUM_CHANNELS) begin
            prod_in[i] = PROD_W'(diff[i]) * PROD_W'(cfg.scale);
         end else begin
            prod_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         time_ff <= in_time;
         for (int i = 0; i < LANES; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // Drop the fraction and clamp anything above the current range.
   always_comb begin
      mid_item.time_us = time_ff;
      for (int i = 0; i < LANES; i++) begin
         if (|prod_ff[i][PROD_W-1:FRAC_W+AMP_W]) begin
            mid_item.amps[i] = '1;
         end else begin
            mid_item.amps[i] = prod_ff[i][FRAC_W+AMP_W-1:FRAC_W];
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/ocm_back.sv
// Back end: per-channel limit timers, levels, flags and the result word.
`default_nettype none

module ocm_back #(
   parameter int NUM_CHANNELS = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ocm_pkg::cfg_type        cfg,
   input  wire logic                    mid_valid,
   input  wire ocm_pkg::mid_item_type   mid_item,
   output logic                         mid_pop,
   input  wire logic                    out_full,
   output logic                         out_push,
   output ocm_pkg::rsp_item_type        out_item
);
   import ocm_pkg::*;

   level_type         level_ff [LANES];
   level_type         level_in [LANES];
   logic              armed_ff [LANES];
   logic              armed_in [LANES];
   logic [TIME_W-1:0] arm_time_ff [LANES];
   logic [TIME_W-1:0] arm_time_in [LANES];
   logic [TIME_W-1:0] elapsed [LANES];
   logic [LANES-1:0]  hard_hit;
   logic [LANES-1:0]  flag_hit;
   logic              go;

   assign go       = mid_valid && !out_full;
   assign mid_pop  = go;
   assign out_push = go;

   // The hard limit is checked first; an armed channel keeps its original arm time.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         level_in[i]    = level_ff[i];
         armed_in[i]    = armed_ff[i];
         arm_time_in[i] = arm_time_ff[i];
         hard_hit[i]    = 1'b0;
         flag_hit[i]    = 1'b0;
         elapsed[i]     = mid_item.time_us - arm_time_ff[i];
         if (i < NUM_CHANNELS) begin
            if (mid_item.amps[i] >= cfg.hard_limit) begin
               if (!armed_ff[i]) begin
                  armed_in[i]    = 1'b1;
                  arm_time_in[i] = mid_item.time_us;
               end else if (elapsed[i] >= TIME_W'(cfg.hard_hold)) begin
                  level_in[i] = LEVEL_HARD;
                  flag_hit[i] = 1'b1;
                  hard_hit[i] = 1'b1;
               end
            end else if (mid_item.amps[i] >= cfg.soft_limit) begin
               if (!armed_ff[i]) begin
                  armed_in[i]    = 1'b1;
                  arm_time_in[i] = mid_item.time_us;
               end else if (elapsed[i] >= TIME_W'(cfg.soft_hold)) begin
                  level_in[i] = LEVEL_SOFT;
                  flag_hit[i] = 1'b1;
               end
            end else begin
               armed_in[i]    = 1'b0;
               arm_time_in[i] = '0;
               level_in[i]    = LEVEL_OK;
            end
         end
      end
   end

   always_comb begin
      out_item.amps  = mid_item.amps;
      out_item.flags = flag_hit;
      out_item.estop = |hard_hit;
      out_item.total = '0;
      for (int i = 0; i < LANES; i++) begin
         out_item.total  = out_item.total + TOTAL_W'(mid_item.amps[i]);
         out_item.levels[i] = level_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            level_ff[i]    <= LEVEL_OK;
            armed_ff[i]    <= 1'b0;
            arm_time_ff[i] <= '0;
         end
      end else if (go) begin
         for (int i = 0; i < LANES; i++) begin
            level_ff[i]    <= level_in[i];
            armed_ff[i]    <= armed_in[i];
            arm_time_ff[i] <= arm_time_in[i];
         end
      end
   end

endmodule

`default_nettype wire
